// ----- rtl/ttri_pkg.sv -----
// ----------------------------------------------------------------------------
// ttri_pkg
// shared widths, register codes and beat structures of the two-view
// triangulation pipeline
// ----------------------------------------------------------------------------
package ttri_pkg;

  localparam int VEC_W      = 24;  // clipped ray component, q12.12
  localparam int ROT_W      = 16;  // rotation entry, q2.14
  localparam int ROT_FRAC   = 14;
  localparam int COORD_FRAC = 12;
  localparam int TR_W       = 16;  // translation entry, q8.8
  localparam int T_W        = 20;  // translation scaled to 12 fraction bits
  localparam int TR_SH      = T_W - TR_W;
  localparam int PR_W       = 2 * VEC_W;
  localparam int DOT_W      = 50;
  localparam int HALF_W     = 25;
  localparam int HI_W       = DOT_W - HALF_W;
  localparam int PROD_W     = 100;
  localparam int ROUND_SH   = 17;  // 2^16 output scale and the doubled divisor
  localparam int N_W        = PROD_W + ROUND_SH + 1;
  localparam int D_W        = PROD_W + 1;
  localparam int Q_W        = 44;  // quotient bits kept, larger saturates anyway
  localparam int QH_W       = Q_W / 2;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = 48;
  localparam int THR_W      = 32;
  localparam int IDX_W      = 3;
  localparam int PAR_DEN_EXP = 48;

  localparam logic [CFG_W-1:0] ROT0_RST = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] ROT1_RST = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] ROT2_RST = 48'h4000_0000_0000;
  localparam logic [THR_W-1:0] THR_RST  = 32'd1;
  localparam logic [PROD_W-1:0] PAR_DEN = PROD_W'(1) << PAR_DEN_EXP;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT0   = 3'd0,
    REG_ROT1   = 3'd1,
    REG_ROT2   = 3'd2,
    REG_TRANS  = 3'd3,
    REG_THRESH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [VEC_W-1:0] v1x;
    logic [VEC_W-1:0] v1y;
    logic             sat;
    logic             par;
    logic             sneg;
    logic             last;
  } side_t;

  typedef struct packed {
    logic [DOT_W-1:0] a;
    logic [DOT_W-1:0] b;
    logic [DOT_W-1:0] c;
    logic [DOT_W-1:0] d;
    logic [DOT_W-1:0] e;
  } dots_t;

  typedef struct packed {
    logic [PROD_W-1:0] ac;
    logic [PROD_W-1:0] bb;
    logic [PROD_W-1:0] cd;
    logic [PROD_W-1:0] be;
  } prods_t;

endpackage

// ----- rtl/ttri_front.sv -----
// ----------------------------------------------------------------------------
// ttri_front
// ray forming and dot products: five register stages from image points to
// the five dot products
// ----------------------------------------------------------------------------
module ttri_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [COORD_WIDTH-1:0]      x0,
  input  logic [COORD_WIDTH-1:0]      y0,
  input  logic [COORD_WIDTH-1:0]      x1,
  input  logic [COORD_WIDTH-1:0]      y1,
  input  logic                        last,
  input  logic [ttri_pkg::CFG_W-1:0]  rot0,
  input  logic [ttri_pkg::CFG_W-1:0]  rot1,
  input  logic [ttri_pkg::CFG_W-1:0]  rot2,
  input  logic [ttri_pkg::CFG_W-1:0]  trans,
  output logic                        out_valid,
  output ttri_pkg::dots_t             dots,
  output ttri_pkg::side_t             side
);
  import ttri_pkg::*;

  localparam int RP_W   = ROT_W + COORD_WIDTH;
  localparam int SW     = RP_W + 2;
  localparam int SH_W   = SW - ROT_FRAC;
  localparam int WIDE   = (SH_W > VEC_W) ? SH_W : VEC_W;
  localparam int RND    = 1 << (ROT_FRAC - 1);
  localparam int ONE_SQ = 1 << (2 * COORD_FRAC);

  // {clipped, value}
  function automatic logic [VEC_W:0] clip_vec(input logic [WIDE-1:0] v);
    logic ovf;
    ovf = !((&v[WIDE-1:VEC_W-1]) || !(|v[WIDE-1:VEC_W-1]));
    if (!ovf) return {1'b0, v[VEC_W-1:0]};
    else if (v[WIDE-1]) return {1'b1, 1'b1, {(VEC_W-1){1'b0}}};
    else return {1'b1, 1'b0, {(VEC_W-1){1'b1}}};
  endfunction

  logic signed [ROT_W-1:0] rot_e [3][3];
  logic signed [T_W-1:0]   t_e [3];
  logic [CFG_W-1:0]        rows [3];

  always_comb begin
    rows[0] = rot0;
    rows[1] = rot1;
    rows[2] = rot2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_e[i][j] = signed'(rows[i][ROT_W*j +: ROT_W]);
      end
      t_e[i] = signed'({trans[TR_W*i +: TR_W], {TR_SH{1'b0}}});
    end
  end

  // stage 1: clip first ray
  logic [VEC_W:0] cx, cy;
  assign cx = clip_vec(WIDE'(signed'(x0)));
  assign cy = clip_vec(WIDE'(signed'(y0)));

  logic                          s1_valid, s1_sat, s1_last;
  logic signed [VEC_W-1:0]       s1_v1x, s1_v1y;
  logic signed [COORD_WIDTH-1:0] s1_x1, s1_y1;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_v1x  <= signed'(cx[VEC_W-1:0]);
      s1_v1y  <= signed'(cy[VEC_W-1:0]);
      s1_sat  <= cx[VEC_W] | cy[VEC_W];
      s1_x1   <= signed'(x1);
      s1_y1   <= signed'(y1);
      s1_last <= last;
    end
  end

  // stage 2: rotation products
  logic                    s2_valid, s2_sat, s2_last;
  logic signed [VEC_W-1:0] s2_v1x, s2_v1y;
  logic signed [RP_W-1:0]  s2_px [3];
  logic signed [RP_W-1:0]  s2_py [3];

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_px[i] <= rot_e[i][0] * s1_x1;
        s2_py[i] <= rot_e[i][1] * s1_y1;
      end
      s2_v1x  <= s1_v1x;
      s2_v1y  <= s1_v1y;
      s2_sat  <= s1_sat;
      s2_last <= s1_last;
    end
  end

  // stage 3: second ray, rounded to 12 fraction bits and clipped
  logic signed [SW-1:0] v2_sum [3];
  logic [VEC_W:0]       v2_clip [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v2_sum[i] = SW'(s2_px[i]) + SW'(s2_py[i]) + (SW'(rot_e[i][2]) <<< COORD_FRAC)
                  + SW'(RND);
      v2_clip[i] = clip_vec(WIDE'(v2_sum[i] >>> ROT_FRAC));
    end
  end

  logic                    s3_valid, s3_sat, s3_last;
  logic signed [VEC_W-1:0] s3_v1x, s3_v1y;
  logic signed [VEC_W-1:0] s3_v2 [3];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
    if (en) begin
      for (int i = 0; i < 3; i++) s3_v2[i] <= signed'(v2_clip[i][VEC_W-1:0]);
      s3_sat  <= s2_sat | v2_clip[0][VEC_W] | v2_clip[1][VEC_W] | v2_clip[2][VEC_W];
      s3_v1x  <= s2_v1x;
      s3_v1y  <= s2_v1y;
      s3_last <= s2_last;
    end
  end

  // stage 4: component products
  logic                    s4_valid, s4_sat, s4_last;
  logic signed [VEC_W-1:0] s4_v1x, s4_v1y, s4_v2z;
  logic signed [PR_W-1:0]  s4_a0, s4_a1, s4_b0, s4_b1, s4_c0, s4_c1, s4_c2;
  logic signed [PR_W-1:0]  s4_d0, s4_d1, s4_e0, s4_e1, s4_e2;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
    if (en) begin
      s4_a0   <= s3_v1x * s3_v1x;
      s4_a1   <= s3_v1y * s3_v1y;
      s4_b0   <= s3_v1x * s3_v2[0];
      s4_b1   <= s3_v1y * s3_v2[1];
      s4_c0   <= s3_v2[0] * s3_v2[0];
      s4_c1   <= s3_v2[1] * s3_v2[1];
      s4_c2   <= s3_v2[2] * s3_v2[2];
      s4_d0   <= t_e[0] * s3_v1x;
      s4_d1   <= t_e[1] * s3_v1y;
      s4_e0   <= t_e[0] * s3_v2[0];
      s4_e1   <= t_e[1] * s3_v2[1];
      s4_e2   <= t_e[2] * s3_v2[2];
      s4_v2z  <= s3_v2[2];
      s4_v1x  <= s3_v1x;
      s4_v1y  <= s3_v1y;
      s4_sat  <= s3_sat;
      s4_last <= s3_last;
    end
  end

  // stage 5: dot product sums, the z of ray 1 is one
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s4_valid;
    if (en) begin
      dots.a <= DOT_W'(s4_a0) + DOT_W'(s4_a1) + DOT_W'(ONE_SQ);
      dots.b <= DOT_W'(s4_b0) + DOT_W'(s4_b1) + (DOT_W'(s4_v2z) <<< COORD_FRAC);
      dots.c <= DOT_W'(s4_c0) + DOT_W'(s4_c1) + DOT_W'(s4_c2);
      dots.d <= DOT_W'(s4_d0) + DOT_W'(s4_d1) + (DOT_W'(t_e[2]) <<< COORD_FRAC);
      dots.e <= DOT_W'(s4_e0) + DOT_W'(s4_e1) + DOT_W'(s4_e2);
      side.v1x  <= s4_v1x;
      side.v1y  <= s4_v1y;
      side.sat  <= s4_sat;
      side.par  <= 1'b0;
      side.sneg <= 1'b0;
      side.last <= s4_last;
    end
  end

endmodule

// ----- rtl/ttri_dmul.sv -----
// ----------------------------------------------------------------------------
// ttri_dmul
// four signed 50x50 products (a*c, b*b, c*d, b*e) from half-word partial
// products over two register stages
// ----------------------------------------------------------------------------
module ttri_dmul (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ttri_pkg::dots_t  dots,
  input  ttri_pkg::side_t  in_side,
  output logic             out_valid,
  output ttri_pkg::prods_t prods,
  output ttri_pkg::side_t  out_side
);
  import ttri_pkg::*;

  localparam int LL_W = 2 * (HALF_W + 1);
  localparam int LH_W = HALF_W + 1 + HI_W;
  localparam int HH_W = 2 * HI_W;

  logic [DOT_W-1:0] opa [4];
  logic [DOT_W-1:0] opb [4];

  always_comb begin
    opa[0] = dots.a;  opb[0] = dots.c;
    opa[1] = dots.b;  opb[1] = dots.b;
    opa[2] = dots.c;  opb[2] = dots.d;
    opa[3] = dots.b;  opb[3] = dots.e;
  end

  // low halves unsigned, high halves signed
  logic signed [LL_W-1:0] pll [4];
  logic signed [LH_W-1:0] plh [4];
  logic signed [LH_W-1:0] phl [4];
  logic signed [HH_W-1:0] phh [4];
  logic                   m1_valid;
  side_t                  m1_side;

  always_ff @(posedge clk) begin
    if (rst) m1_valid <= 1'b0;
    else if (en) m1_valid <= in_valid;
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pll[j] <= signed'({1'b0, opa[j][HALF_W-1:0]}) * signed'({1'b0, opb[j][HALF_W-1:0]});
        plh[j] <= signed'({1'b0, opa[j][HALF_W-1:0]}) * signed'(opb[j][DOT_W-1:HALF_W]);
        phl[j] <= signed'(opa[j][DOT_W-1:HALF_W]) * signed'({1'b0, opb[j][HALF_W-1:0]});
        phh[j] <= signed'(opa[j][DOT_W-1:HALF_W]) * signed'(opb[j][DOT_W-1:HALF_W]);
      end
      m1_side <= in_side;
    end
  end

  logic signed [PROD_W-1:0] sum [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = (PROD_W'(phh[j]) <<< (2 * HALF_W))
               + ((PROD_W'(plh[j]) + PROD_W'(phl[j])) <<< HALF_W)
               + PROD_W'(pll[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= m1_valid;
    if (en) begin
      prods.ac <= sum[0];
      prods.bb <= sum[1];
      prods.cd <= sum[2];
      prods.be <= sum[3];
      out_side <= m1_side;
    end
  end

endmodule

// ----- rtl/ttri_div.sv -----
// ----------------------------------------------------------------------------
// ttri_div
// pipelined restoring divider: operand forming, range check, then one
// quotient bit per stage; quotient clamped to all ones on range overflow
// ----------------------------------------------------------------------------
module ttri_div #(
  parameter int TAG_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ttri_pkg::PROD_W-1:0]  nmag,
  input  logic [ttri_pkg::PROD_W-1:0]  den,
  input  logic [TAG_W-1:0]             in_tag,
  output logic                         out_valid,
  output logic [ttri_pkg::Q_W-1:0]     quot,
  output logic [TAG_W-1:0]             out_tag
);
  import ttri_pkg::*;

  localparam int CMP_W = D_W + Q_W;

  // operands: (2|num|*2^16 + den) / (2*den) rounds half away from zero
  logic             p_valid;
  logic [N_W-1:0]   p_n;
  logic [D_W-1:0]   p_d;
  logic [TAG_W-1:0] p_tag;

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= in_valid;
    if (en) begin
      p_n   <= (N_W'(nmag) << ROUND_SH) + N_W'(den);
      p_d   <= D_W'(den) << 1;
      p_tag <= in_tag;
    end
  end

  logic             st_valid [Q_W+1];
  logic             st_ovf   [Q_W+1];
  logic [N_W-1:0]   st_rem   [Q_W+1];
  logic [D_W-1:0]   st_d     [Q_W+1];
  logic [Q_W-1:0]   st_q     [Q_W+1];
  logic [TAG_W-1:0] st_tag   [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) st_valid[0] <= 1'b0;
    else if (en) st_valid[0] <= p_valid;
    if (en) begin
      st_ovf[0] <= CMP_W'(p_n) >= (CMP_W'(p_d) << Q_W);
      st_rem[0] <= p_n;
      st_d[0]   <= p_d;
      st_q[0]   <= '0;
      st_tag[0] <= p_tag;
    end
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_bit
    localparam int SH = Q_W - 1 - g;
    logic [CMP_W-1:0] trial;
    logic             ge;

    assign trial = CMP_W'(st_d[g]) << SH;
    assign ge    = CMP_W'(st_rem[g]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) st_valid[g+1] <= 1'b0;
      else if (en) st_valid[g+1] <= st_valid[g];
      if (en) begin
        st_rem[g+1] <= ge ? N_W'(CMP_W'(st_rem[g]) - trial) : st_rem[g];
        st_q[g+1]   <= st_q[g] | (Q_W'(ge) << SH);
        st_d[g+1]   <= st_d[g];
        st_ovf[g+1] <= st_ovf[g];
        st_tag[g+1] <= st_tag[g];
      end
    end
  end

  assign out_valid = st_valid[Q_W];
  assign quot      = st_ovf[Q_W] ? {Q_W{1'b1}} : st_q[Q_W];
  assign out_tag   = st_tag[Q_W];

endmodule

// ----- rtl/ttri_back.sv -----
// ----------------------------------------------------------------------------
// ttri_back
// scales the first ray by the depth, rounds, saturates to q16.16 and holds
// the output register
// ----------------------------------------------------------------------------
module ttri_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ttri_pkg::Q_W-1:0]    quot,
  input  ttri_pkg::side_t             side,
  output logic                        out_valid,
  output logic [ttri_pkg::OUT_W-1:0]  point_x,
  output logic [ttri_pkg::OUT_W-1:0]  point_y,
  output logic [ttri_pkg::OUT_W-1:0]  point_z,
  output logic                        rays_parallel,
  output logic                        result_saturated,
  output logic                        last_point
);
  import ttri_pkg::*;

  localparam int MP_W  = VEC_W + QH_W;
  localparam int SUM_W = VEC_W + Q_W + 1;
  localparam int RND   = 1 << (COORD_FRAC - 1);

  // {saturated, value}
  function automatic logic [OUT_W:0] pack(input logic [SUM_W-1:0] mag, input logic neg);
    logic [SUM_W-1:0] lim;
    logic [OUT_W-1:0] v;
    logic             sat;
    lim = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(!neg);
    sat = mag > lim;
    v   = sat ? lim[OUT_W-1:0] : mag[OUT_W-1:0];
    if (neg) v = -v;
    return {sat, v};
  endfunction

  logic [VEC_W-1:0] mx, my;
  assign mx = side.v1x[VEC_W-1] ? -side.v1x : side.v1x;
  assign my = side.v1y[VEC_W-1] ? -side.v1y : side.v1y;

  logic             b1_valid;
  logic [MP_W-1:0]  pxl, pxh, pyl, pyh;
  logic [Q_W-1:0]   b1_q;
  side_t            b1_side;

  always_ff @(posedge clk) begin
    if (rst) b1_valid <= 1'b0;
    else if (en) b1_valid <= in_valid;
    if (en) begin
      pxl     <= MP_W'(mx) * MP_W'(quot[QH_W-1:0]);
      pxh     <= MP_W'(mx) * MP_W'(quot[Q_W-1:QH_W]);
      pyl     <= MP_W'(my) * MP_W'(quot[QH_W-1:0]);
      pyh     <= MP_W'(my) * MP_W'(quot[Q_W-1:QH_W]);
      b1_q    <= quot;
      b1_side <= side;
    end
  end

  logic [SUM_W-1:0] sx, sy;
  logic [OUT_W:0]   px, py, pz;

  always_comb begin
    sx = ((SUM_W'(pxh) << QH_W) + SUM_W'(pxl) + SUM_W'(RND)) >> COORD_FRAC;
    sy = ((SUM_W'(pyh) << QH_W) + SUM_W'(pyl) + SUM_W'(RND)) >> COORD_FRAC;
    px = pack(sx, b1_side.sneg ^ b1_side.v1x[VEC_W-1]);
    py = pack(sy, b1_side.sneg ^ b1_side.v1y[VEC_W-1]);
    pz = pack(SUM_W'(b1_q), b1_side.sneg);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= b1_valid;
    if (en) begin
      point_x          <= px[OUT_W-1:0];
      point_y          <= py[OUT_W-1:0];
      point_z          <= pz[OUT_W-1:0];
      rays_parallel    <= b1_side.par;
      result_saturated <= b1_side.sat | px[OUT_W] | py[OUT_W] | pz[OUT_W];
      last_point       <= b1_side.last;
    end
  end

endmodule

// ----- rtl/two_view_ray_triangulation.sv -----
// ----------------------------------------------------------------------------
// two_view_ray_triangulation
// throughput: one pair per cycle while the output is not stalled; the divider's
// 44 quotient-bit stages set the depth
// a stalled output freezes every stage at once, nothing is lost or repeated
// reset: synchronous, clears all valid bits and loads identity rotation,
// zero baseline and a threshold of one
// ----------------------------------------------------------------------------
module two_view_ray_triangulation #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // pair channel
  input  logic                        pair_valid,
  output logic                        pair_stall,
  input  logic [COORD_WIDTH-1:0]      first_x,
  input  logic [COORD_WIDTH-1:0]      first_y,
  input  logic [COORD_WIDTH-1:0]      second_x,
  input  logic [COORD_WIDTH-1:0]      second_y,
  input  logic                        last_pair,
  // point channel
  output logic                        point_valid,
  input  logic                        point_stall,
  output logic [ttri_pkg::OUT_W-1:0]  point_x,
  output logic [ttri_pkg::OUT_W-1:0]  point_y,
  output logic [ttri_pkg::OUT_W-1:0]  point_z,
  output logic                        rays_parallel,
  output logic                        result_saturated,
  output logic                        last_point,
  // configuration writes
  input  logic                        write_enable,
  input  logic [ttri_pkg::IDX_W-1:0]  write_index,
  input  logic [ttri_pkg::CFG_W-1:0]  write_data
);
  import ttri_pkg::*;

  // the whole pipe advances unless the output register holds an untaken beat
  logic en;
  assign en         = !point_valid || !point_stall;
  assign pair_stall = !en;

  // configuration registers; the user must write them only while the pipe is empty, the block does not enforce it
  logic [CFG_W-1:0] rot_row0, rot_row1, rot_row2, trans;
  logic [THR_W-1:0] thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0 <= ROT0_RST;
      rot_row1 <= ROT1_RST;
      rot_row2 <= ROT2_RST;
      trans    <= '0;
      thresh   <= THR_RST;
    end else if (write_enable) begin
      unique case (reg_idx_t'(write_index))
        REG_ROT0:   rot_row0 <= write_data;
        REG_ROT1:   rot_row1 <= write_data;
        REG_ROT2:   rot_row2 <= write_data;
        REG_TRANS:  trans    <= write_data;
        REG_THRESH: thresh   <= write_data[THR_W-1:0];
        default:    ; // unused index, write dropped
      endcase
    end
  end

  // stages 1..5: rays and dot products a, b, c, d, e
  logic  f_valid;
  dots_t f_dots;
  side_t f_side;

  ttri_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pair_valid),
    .x0        (first_x),
    .y0        (first_y),
    .x1        (second_x),
    .y1        (second_y),
    .last      (last_pair),
    .rot0      (rot_row0),
    .rot1      (rot_row1),
    .rot2      (rot_row2),
    .trans     (trans),
    .out_valid (f_valid),
    .dots      (f_dots),
    .side      (f_side)
  );

  // stages 6..7: the four wide products
  logic   m_valid;
  prods_t m_prods;
  side_t  m_side;

  ttri_dmul u_dmul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .dots      (f_dots),
    .in_side   (f_side),
    .out_valid (m_valid),
    .prods     (m_prods),
    .out_side  (m_side)
  );

  // stage 8: denominator a*c - b*b and numerator c*d - b*e, exact
  logic                     s8_valid;
  logic signed [PROD_W-1:0] s8_den, s8_num;
  side_t                    s8_side;

  always_ff @(posedge clk) begin
    if (rst) s8_valid <= 1'b0;
    else if (en) s8_valid <= m_valid;
    if (en) begin
      s8_den  <= signed'(m_prods.ac) - signed'(m_prods.bb);
      s8_num  <= signed'(m_prods.cd) - signed'(m_prods.be);
      s8_side <= m_side;
    end
  end

  // stage 9: near-parallel rays (negative denominator or at/below the
  // threshold) divide by one instead; numerator split into sign and magnitude
  logic par;
  assign par = s8_den[PROD_W-1] || ($unsigned(s8_den) <= PROD_W'(thresh));

  // side data with the parallel flag and the numerator sign filled in
  side_t s8_side_upd;

  always_comb begin
    s8_side_upd      = s8_side;
    s8_side_upd.par  = par;
    s8_side_upd.sneg = s8_num[PROD_W-1];
  end

  logic              s9_valid;
  logic [PROD_W-1:0] s9_den, s9_nmag;
  side_t             s9_side;

  always_ff @(posedge clk) begin
    if (rst) s9_valid <= 1'b0;
    else if (en) s9_valid <= s8_valid;
    if (en) begin
      s9_den  <= par ? PAR_DEN : $unsigned(s8_den);
      s9_nmag <= s8_num[PROD_W-1] ? $unsigned(-s8_num) : $unsigned(s8_num);
      s9_side <= s8_side_upd;
    end
  end

  // stages 10..55: depth s in q.16, side data rides along as the tag
  logic                  d_valid;
  logic [Q_W-1:0]        d_quot;
  logic [$bits(side_t)-1:0] d_tag;

  ttri_div #(
    .TAG_W ($bits(side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s9_valid),
    .nmag      (s9_nmag),
    .den       (s9_den),
    .in_tag    (s9_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .out_tag   (d_tag)
  );

  // stages 56..57: x0*s, y0*s, s and the output register
  ttri_back u_back (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (d_valid),
    .quot             (d_quot),
    .side             (side_t'(d_tag)),
    .out_valid        (point_valid),
    .point_x          (point_x),
    .point_y          (point_y),
    .point_z          (point_z),
    .rays_parallel    (rays_parallel),
    .result_saturated (result_saturated),
    .last_point       (last_point)
  );

  // checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !point_valid)
    else $error("output beat valid after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_stall) |=> $stable({s8_valid, s9_valid}))
    else $error("pipe moved while output stalled");

  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !result_saturated && point_z == '0) |->
      (point_x == '0 && point_y == '0))
    else $error("zero depth with non-zero x or y");

endmodule
